[src/pgpk_pkg.sv]
package pgpk_pkg;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  byte_role;
    logic [3:0]  packet_kind;
    logic        packet_done;
    logic [2:0]  mpi_number;
    logic [31:0] key_field_value;
    logic [2:0]  error_code;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_LENGTH = 3'b010,
    PH_BODY   = 3'b100
  } outer_phase_t;

  typedef enum logic [8:0] {
    KP_VERSION = 9'b000000001,
    KP_TIME    = 9'b000000010,
    KP_ALGO    = 9'b000000100,
    KP_MPILEN  = 9'b000001000,
    KP_MPIBODY = 9'b000010000,
    KP_S2K     = 9'b000100000,
    KP_CHECK   = 9'b001000000,
    KP_TAIL    = 9'b010000000,
    KP_SKIP    = 9'b100000000
  } key_phase_t;

  localparam logic [3:0] ROLE_HEADER   = 4'd0;
  localparam logic [3:0] ROLE_LENGTH   = 4'd1;
  localparam logic [3:0] ROLE_VERSION  = 4'd2;
  localparam logic [3:0] ROLE_TIME     = 4'd3;
  localparam logic [3:0] ROLE_ALGO     = 4'd4;
  localparam logic [3:0] ROLE_MPI_LEN  = 4'd5;
  localparam logic [3:0] ROLE_MPI_BODY = 4'd6;
  localparam logic [3:0] ROLE_S2K      = 4'd7;
  localparam logic [3:0] ROLE_CHECKSUM = 4'd8;
  localparam logic [3:0] ROLE_OTHER    = 4'd9;
  localparam logic [3:0] ROLE_SKIPPED  = 4'd10;
  localparam logic [3:0] ROLE_IGNORED  = 4'd11;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BIT7_CLEAR = 3'd1;
  localparam logic [2:0] ERR_NEW_FORMAT = 3'd2;
  localparam logic [2:0] ERR_LEN_TYPE   = 3'd3;
  localparam logic [2:0] ERR_NOT_V4     = 3'd4;
  localparam logic [2:0] ERR_MPI_OVERRUN = 3'd5;
  localparam logic [2:0] ERR_BAD_TRAILER = 3'd6;
  localparam logic [2:0] ERR_SHORT_KEY  = 3'd7;

  localparam logic [3:0] TAG_SECRET_KEY = 4'd5;
  localparam logic [3:0] TAG_PUBLIC_KEY = 4'd6;
  localparam logic [3:0] TAG_PUBLIC_SUB = 4'd14;

  localparam logic [7:0] KEY_VERSION = 8'd4;

  localparam logic [2:0] MPI_N = 3'd0;
  localparam logic [2:0] MPI_E = 3'd1;
  localparam logic [2:0] MPI_D = 3'd2;
  localparam logic [2:0] MPI_U = 3'd5;

endpackage

[src/pgpk_in_reg.sv]
module pgpk_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  pgpk_pkg::in_item_t  byte_data,
  output logic                item_valid,
  input  logic                item_take,
  output pgpk_pkg::in_item_t  item
);

  logic               valid;
  pgpk_pkg::in_item_t data;

  assign byte_ready = !valid || item_take;
  assign item_valid = valid;
  assign item       = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (byte_ready) begin
      valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      data <= byte_data;
    end
  end

endmodule

[src/pgpk_core.sv]
module pgpk_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  pgpk_pkg::in_item_t  item,
  output pgpk_pkg::out_item_t result
);

  logic                   halted, halted_next;
  pgpk_pkg::outer_phase_t outer, outer_next;
  logic                   two_len, two_len_next;
  logic                   len_seen, len_seen_next;
  logic [3:0]             tag, tag_next;
  logic [15:0]            pbl, pbl_next;
  pgpk_pkg::key_phase_t   kp, kp_next;
  logic [1:0]             fbc, fbc_next;
  logic [2:0]             mi, mi_next;
  logic [12:0]            mbl, mbl_next;
  logic [31:0]            acc, acc_next;

  logic [7:0]  b;
  logic [15:0] rem;
  logic [15:0] len_val;
  logic [15:0] acc16;
  logic [16:0] sum17;
  logic [13:0] nbytes;
  logic        key_tag;
  logic        mpi_fin;

  assign b       = item.stream_byte;
  assign rem     = pbl - 16'd1;
  assign len_val = {pbl[7:0], b};
  assign acc16   = {acc[7:0], b};
  assign sum17   = {1'b0, acc16} + 17'd7;
  assign nbytes  = sum17[16:3];
  assign key_tag = (tag == pgpk_pkg::TAG_SECRET_KEY) || (tag == pgpk_pkg::TAG_PUBLIC_KEY) ||
                   (tag == pgpk_pkg::TAG_PUBLIC_SUB);

  always_comb begin
    halted_next   = halted;
    outer_next    = outer;
    two_len_next  = two_len;
    len_seen_next = len_seen;
    tag_next      = tag;
    pbl_next      = pbl;
    kp_next       = kp;
    fbc_next      = fbc;
    mi_next       = mi;
    mbl_next      = mbl;
    acc_next      = acc;
    mpi_fin       = 1'b0;

    result.byte_role       = pgpk_pkg::ROLE_IGNORED;
    result.packet_kind     = tag;
    result.packet_done     = 1'b0;
    result.mpi_number      = 3'd0;
    result.key_field_value = 32'd0;
    result.error_code      = pgpk_pkg::ERR_NONE;

    if (!halted) begin
      case (outer)
        pgpk_pkg::PH_HEADER: begin
          result.byte_role   = pgpk_pkg::ROLE_HEADER;
          tag_next           = b[5:2];
          result.packet_kind = b[5:2];
          if (!b[7]) begin
            result.error_code = pgpk_pkg::ERR_BIT7_CLEAR;
            halted_next       = 1'b1;
          end else if (b[6]) begin
            result.error_code = pgpk_pkg::ERR_NEW_FORMAT;
            halted_next       = 1'b1;
          end else if (b[1]) begin
            result.error_code = pgpk_pkg::ERR_LEN_TYPE;
            halted_next       = 1'b1;
          end else begin
            two_len_next  = b[0];
            len_seen_next = 1'b0;
            pbl_next      = 16'd0;
            outer_next    = pgpk_pkg::PH_LENGTH;
          end
        end
        pgpk_pkg::PH_LENGTH: begin
          result.byte_role = pgpk_pkg::ROLE_LENGTH;
          pbl_next         = len_val;
          if (two_len && !len_seen) begin
            len_seen_next = 1'b1;
          end else begin
            kp_next  = pgpk_pkg::KP_VERSION;
            fbc_next = 2'd0;
            mi_next  = 3'd0;
            mbl_next = 13'd0;
            acc_next = 32'd0;
            if (len_val == 16'd0) begin
              result.packet_done = 1'b1;
              outer_next         = pgpk_pkg::PH_HEADER;
              if (key_tag) begin
                result.error_code = pgpk_pkg::ERR_SHORT_KEY;
              end
            end else begin
              outer_next = pgpk_pkg::PH_BODY;
            end
          end
        end
        pgpk_pkg::PH_BODY: begin
          pbl_next = rem;
          if (rem == 16'd0) begin
            result.packet_done = 1'b1;
            outer_next         = pgpk_pkg::PH_HEADER;
          end
          if (!key_tag) begin
            result.byte_role = pgpk_pkg::ROLE_OTHER;
          end else begin
            case (kp)
              pgpk_pkg::KP_VERSION: begin
                result.byte_role = pgpk_pkg::ROLE_VERSION;
                if (b != pgpk_pkg::KEY_VERSION) begin
                  result.error_code = pgpk_pkg::ERR_NOT_V4;
                  kp_next           = pgpk_pkg::KP_SKIP;
                end else begin
                  kp_next  = pgpk_pkg::KP_TIME;
                  fbc_next = 2'd0;
                  acc_next = 32'd0;
                end
              end
              pgpk_pkg::KP_TIME: begin
                result.byte_role       = pgpk_pkg::ROLE_TIME;
                acc_next               = {acc[23:0], b};
                result.key_field_value = {acc[23:0], b};
                if (fbc == 2'd3) begin
                  kp_next = pgpk_pkg::KP_ALGO;
                end else begin
                  fbc_next = fbc + 2'd1;
                end
              end
              pgpk_pkg::KP_ALGO: begin
                result.byte_role = pgpk_pkg::ROLE_ALGO;
                mi_next          = pgpk_pkg::MPI_N;
                kp_next          = pgpk_pkg::KP_MPILEN;
                fbc_next         = 2'd0;
                acc_next         = 32'd0;
              end
              pgpk_pkg::KP_MPILEN: begin
                result.byte_role  = pgpk_pkg::ROLE_MPI_LEN;
                result.mpi_number = mi;
                if (fbc == 2'd0) begin
                  acc_next               = {24'd0, b};
                  fbc_next               = 2'd1;
                  result.key_field_value = {24'd0, b};
                end else begin
                  acc_next               = {16'd0, acc16};
                  result.key_field_value = {16'd0, acc16};
                  if ({2'd0, nbytes} > rem) begin
                    result.error_code = pgpk_pkg::ERR_MPI_OVERRUN;
                    kp_next           = pgpk_pkg::KP_SKIP;
                  end else if (nbytes == 14'd0) begin
                    mpi_fin = 1'b1;
                  end else begin
                    mbl_next = nbytes[12:0] - 13'd1;
                    kp_next  = pgpk_pkg::KP_MPIBODY;
                  end
                end
              end
              pgpk_pkg::KP_MPIBODY: begin
                result.byte_role       = pgpk_pkg::ROLE_MPI_BODY;
                result.mpi_number      = mi;
                result.key_field_value = acc;
                if (mbl == 13'd0) begin
                  mpi_fin = 1'b1;
                end else begin
                  mbl_next = mbl - 13'd1;
                end
              end
              pgpk_pkg::KP_S2K: begin
                result.byte_role = pgpk_pkg::ROLE_S2K;
                mi_next          = pgpk_pkg::MPI_D;
                kp_next          = pgpk_pkg::KP_MPILEN;
                fbc_next         = 2'd0;
                acc_next         = 32'd0;
              end
              pgpk_pkg::KP_CHECK: begin
                result.byte_role = pgpk_pkg::ROLE_CHECKSUM;
                if (fbc == 2'd0) begin
                  fbc_next = 2'd1;
                end else begin
                  kp_next = pgpk_pkg::KP_TAIL;
                end
              end
              pgpk_pkg::KP_TAIL: begin
                result.byte_role = pgpk_pkg::ROLE_OTHER;
              end
              default: begin
                result.byte_role = pgpk_pkg::ROLE_SKIPPED;
                kp_next          = pgpk_pkg::KP_SKIP;
              end
            endcase

            // end of one MPI: move to the next field
            if (mpi_fin) begin
              if (mi == pgpk_pkg::MPI_N) begin
                mi_next  = pgpk_pkg::MPI_E;
                kp_next  = pgpk_pkg::KP_MPILEN;
                fbc_next = 2'd0;
                acc_next = 32'd0;
              end else if (mi == pgpk_pkg::MPI_E) begin
                kp_next = (tag == pgpk_pkg::TAG_SECRET_KEY) ? pgpk_pkg::KP_S2K :
                                                              pgpk_pkg::KP_TAIL;
              end else if (mi < pgpk_pkg::MPI_U) begin
                mi_next  = mi + 3'd1;
                kp_next  = pgpk_pkg::KP_MPILEN;
                fbc_next = 2'd0;
                acc_next = 32'd0;
              end else if (rem != 16'd2) begin
                result.error_code = pgpk_pkg::ERR_BAD_TRAILER;
                kp_next           = pgpk_pkg::KP_SKIP;
              end else begin
                kp_next  = pgpk_pkg::KP_CHECK;
                fbc_next = 2'd0;
              end
            end

            if (result.packet_done && (result.error_code == pgpk_pkg::ERR_NONE) &&
                (kp_next != pgpk_pkg::KP_TAIL) && (kp_next != pgpk_pkg::KP_SKIP)) begin
              result.error_code = pgpk_pkg::ERR_SHORT_KEY;
            end
          end
        end
        default: begin
          outer_next = pgpk_pkg::PH_HEADER;
        end
      endcase
    end

    if (item.last_byte) begin
      halted_next   = 1'b0;
      outer_next    = pgpk_pkg::PH_HEADER;
      two_len_next  = 1'b0;
      len_seen_next = 1'b0;
      tag_next      = 4'd0;
      pbl_next      = 16'd0;
      kp_next       = pgpk_pkg::KP_VERSION;
      fbc_next      = 2'd0;
      mi_next       = 3'd0;
      mbl_next      = 13'd0;
      acc_next      = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      halted   <= 1'b0;
      outer    <= pgpk_pkg::PH_HEADER;
      two_len  <= 1'b0;
      len_seen <= 1'b0;
      tag      <= 4'd0;
      pbl      <= 16'd0;
      kp       <= pgpk_pkg::KP_VERSION;
      fbc      <= 2'd0;
      mi       <= 3'd0;
      mbl      <= 13'd0;
      acc      <= 32'd0;
    end else if (step) begin
      halted   <= halted_next;
      outer    <= outer_next;
      two_len  <= two_len_next;
      len_seen <= len_seen_next;
      tag      <= tag_next;
      pbl      <= pbl_next;
      kp       <= kp_next;
      fbc      <= fbc_next;
      mi       <= mi_next;
      mbl      <= mbl_next;
      acc      <= acc_next;
    end
  end

  a_header_error_halts: assert property (@(posedge clk) disable iff (rst)
    step && !halted && !item.last_byte &&
    (result.error_code == pgpk_pkg::ERR_BIT7_CLEAR ||
     result.error_code == pgpk_pkg::ERR_NEW_FORMAT ||
     result.error_code == pgpk_pkg::ERR_LEN_TYPE) |=> halted)
    else $error("header error did not halt parser");

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    step && item.last_byte |=> !halted && outer == pgpk_pkg::PH_HEADER && pbl == 16'd0)
    else $error("state not cleared after last byte");

  a_done_role: assert property (@(posedge clk) disable iff (rst)
    step && result.packet_done |->
    result.byte_role != pgpk_pkg::ROLE_HEADER && result.byte_role != pgpk_pkg::ROLE_IGNORED)
    else $error("packet end on header or ignored byte");

  a_mpi_range: assert property (@(posedge clk) disable iff (rst)
    mi <= pgpk_pkg::MPI_U)
    else $error("mpi index out of range");

  a_mpi_number_role: assert property (@(posedge clk) disable iff (rst)
    step && result.mpi_number != 3'd0 |->
    result.byte_role == pgpk_pkg::ROLE_MPI_LEN || result.byte_role == pgpk_pkg::ROLE_MPI_BODY)
    else $error("mpi number on non-mpi byte");

endmodule

[src/pgpk_out_reg.sv]
module pgpk_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 result_valid,
  output logic                 result_ready,
  input  pgpk_pkg::out_item_t  result,
  output logic                 label_valid,
  input  logic                 label_ready,
  output pgpk_pkg::out_item_t  label_data
);

  logic                valid;
  pgpk_pkg::out_item_t data;

  assign result_ready = !valid || label_ready;
  assign label_valid  = valid;
  assign label_data   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (result_ready) begin
      valid <= result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid && result_ready) begin
      data <= result;
    end
  end

endmodule

[src/pgp_packet_key_parser_top.sv]
// channel | signals                              | transfer when
// input   | byte_valid, byte_ready, byte_data    | byte_valid && byte_ready
// output  | label_valid, label_ready, label_data | label_valid && label_ready
//
// One byte per cycle sustained while the output is not stalled; a byte's label is presented
// after it passes one input register and then one result register around the labeling logic.
// rst is synchronous, active high, and returns the parser to expect-header.
// A stalled output holds its label; the input register keeps accepting while the
// result register is free or being drained in the same cycle.
module pgp_packet_key_parser_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  pgpk_pkg::in_item_t   byte_data,
  output logic                 label_valid,
  input  logic                 label_ready,
  output pgpk_pkg::out_item_t  label_data
);

  logic                item_valid;
  logic                result_ready;
  logic                step;
  pgpk_pkg::in_item_t  item;
  pgpk_pkg::out_item_t result;

  assign step = item_valid && result_ready;

  pgpk_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .item_valid (item_valid),
    .item_take  (result_ready),
    .item       (item)
  );

  pgpk_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .result (result)
  );

  pgpk_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .result_valid (item_valid),
    .result_ready (result_ready),
    .result       (result),
    .label_valid  (label_valid),
    .label_ready  (label_ready),
    .label_data   (label_data)
  );

endmodule
